// ===== hw/rtl/hpbei_pkg.sv =====
// package: constants, types and generator step for the bit error injector
`default_nettype none

package hpbei_pkg;

  // default packet length limit
  localparam int unsigned PktMaxBytesDef = 65535;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  typedef enum logic [CfgIdxW-1:0] {
    REG_ERROR_THRESHOLD = 8'd0,
    REG_RNG_SEED        = 8'd1
  } cfg_reg_e;

  // header layout constants
  localparam logic [3:0]  IpVersion4     = 4'd4;
  localparam logic [3:0]  MinHdrWords    = 4'd5;
  localparam logic [7:0]  NibbleMask     = 8'h0F;
  localparam logic [15:0] MinIpBytes     = 16'd20;
  localparam logic [15:0] ProtoBytePos   = 16'd9;
  localparam logic [15:0] TcpOffBytePos  = 16'd12;
  localparam logic [6:0]  TcpHdrBytes    = 7'd20;
  localparam logic [6:0]  UdpHdrBytes    = 7'd8;
  localparam logic [7:0]  ProtoTcp       = 8'd6;
  localparam logic [7:0]  ProtoUdp       = 8'd17;
  localparam logic [15:0] PosSaturate    = 16'hFFFF;
  localparam logic [31:0] SeedFallback   = 32'd1;

  // one xorshift32 step (13, 17, 5)
  function automatic logic [31:0] xs_next(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hpbei_intf.sv =====
// interfaces: byte input stream, result stream and configuration write channel
`default_nettype none

interface hpbei_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_of_packet;
  logic        end_of_packet;
  logic [15:0] packet_length;

  modport source (output valid, data_byte, start_of_packet, end_of_packet, packet_length,
                  input ready);
  modport sink (input valid, data_byte, start_of_packet, end_of_packet, packet_length,
                output ready);
endinterface

interface hpbei_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [3:0] flip_count;

  modport source (output valid, out_byte, out_last, flip_count, input ready);
  modport sink (input valid, out_byte, out_last, flip_count, output ready);
endinterface

interface hpbei_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/header_protected_bit_error_injector.sv =====
// top level: header-protected bit error injector for ipv4 byte streams
//
//   channel | dir | handshake     | payload
//   in_i    | in  | valid / ready | data_byte, start_of_packet, end_of_packet, packet_length
//   out_o   | out | valid / ready | out_byte, out_last, flip_count
//   cfg_i   | in  | valid / ready | index, wdata (0: error_threshold, 1: rng_seed)
//
// one beat per cycle sustained while out_o is ready; each input beat passes through the input register,
// then eight unrolled generator steps and compares into the result register
// reset: threshold 0, generator state 1, bytes pass through until a start of packet
// a waiting result blocks the input only once the input register is full as well; a full
// input register takes a new beat in the cycle the result register is freed; cfg_i is always ready
`default_nettype none

module header_protected_bit_error_injector
  import hpbei_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = PktMaxBytesDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  hpbei_in_if.sink     in_i,
  hpbei_out_if.source  out_o,
  hpbei_cfg_if.sink    cfg_i
);

  localparam logic [15:0] MaxLen = 16'(MAX_PACKET_BYTES);

  // configuration
  logic [31:0] thr_q;
  logic        cfg_fire;
  logic        seed_wr;

  // input register
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_sop_q;
  logic        s1_eop_q;
  logic [15:0] s1_len_q;

  // packet state
  logic [15:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [5:0]  ihb_q, ihb_d;
  logic [7:0]  proto_q, proto_d;
  logic [6:0]  pend_q, pend_d;
  logic        pass_q, pass_d;
  logic [31:0] rs_q, rs_d;

  // result register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic [3:0]  out_flip_q;

  // handshake
  logic in_fire;
  logic s1_adv;
  logic s1_fire;
  logic out_fire;

  // work signals
  logic [15:0] len_clamp;
  logic [3:0]  ihl;
  logic [3:0]  tcp_off;
  logic        flip_en;
  logic [31:0] xs [9];
  logic [7:0]  flip_mask;
  logic [7:0]  res_byte;
  logic [3:0]  res_flips;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign seed_wr     = cfg_fire && (cfg_i.index == REG_RNG_SEED);

  assign s1_adv    = !out_valid_q || out_o.ready;
  assign s1_fire   = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_valid_q && out_o.ready;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_fire && (cfg_i.index == REG_ERROR_THRESHOLD)) begin
      thr_q <= cfg_i.wdata;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.data_byte;
      s1_sop_q  <= in_i.start_of_packet;
      s1_eop_q  <= in_i.end_of_packet;
      s1_len_q  <= in_i.packet_length;
    end
  end

  assign len_clamp = (32'(s1_len_q) > MAX_PACKET_BYTES) ? MaxLen : s1_len_q;
  assign ihl       = 4'(s1_byte_q & NibbleMask);
  assign tcp_off   = s1_byte_q[7:4];

  // header parse: start-of-packet reset, version/ihl, protocol, tcp offset
  always_comb begin
    pos_d   = s1_sop_q ? '0 : pos_q;
    len_d   = s1_sop_q ? len_clamp : len_q;
    ihb_d   = s1_sop_q ? '0 : ihb_q;
    proto_d = s1_sop_q ? '0 : proto_q;
    pend_d  = s1_sop_q ? '0 : pend_q;
    pass_d  = s1_sop_q ? (len_clamp < MinIpBytes) : pass_q;
    if (!pass_d) begin
      if (pos_d == '0) begin
        if ((s1_byte_q[7:4] != IpVersion4) || (ihl < MinHdrWords)) begin
          pass_d = 1'b1;
        end else begin
          ihb_d  = {ihl, 2'b00};
          pend_d = {1'b0, ihl, 2'b00};
        end
      end else if (pos_d == ProtoBytePos) begin
        proto_d = s1_byte_q;
        if ((s1_byte_q == ProtoTcp) && (len_d >= 16'(ihb_d) + 16'(TcpHdrBytes))) begin
          pend_d = 7'(ihb_d) + TcpHdrBytes;
        end else if ((s1_byte_q == ProtoUdp) &&
                     (len_d >= 16'(ihb_d) + 16'(UdpHdrBytes))) begin
          pend_d = 7'(ihb_d) + UdpHdrBytes;
        end
      end else if ((pos_d == 16'(ihb_d) + TcpOffBytePos) && (proto_d == ProtoTcp) &&
                   (len_d >= 16'(ihb_d) + 16'(TcpHdrBytes))) begin
        if (tcp_off < MinHdrWords) begin
          pass_d = 1'b1;
        end else begin
          pend_d = 7'(ihb_d) + 7'({tcp_off, 2'b00});
        end
      end
    end
  end

  assign flip_en = !pass_d && (pos_d >= 16'(pend_d)) && (pos_d < len_d) && (thr_q != '0);

  // eight unrolled generator steps, one per bit from bit 0 up
  always_comb begin
    xs[0] = rs_q;
    for (int k = 0; k < 8; k++) begin
      xs[k+1]      = xs_next(xs[k]);
      flip_mask[k] = flip_en && (xs[k+1] < thr_q);
    end
  end

  assign res_byte  = s1_byte_q ^ flip_mask;
  assign res_flips = 4'($countones(flip_mask));

  // generator state: seed write, else advance by eight when bits were drawn
  always_comb begin
    rs_d = rs_q;
    if (seed_wr) begin
      rs_d = (cfg_i.wdata != '0) ? cfg_i.wdata : SeedFallback;
    end else if (s1_fire && flip_en) begin
      rs_d = xs[8];
    end
  end

  // packet state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      ihb_q   <= '0;
      proto_q <= '0;
      pend_q  <= '0;
      pass_q  <= 1'b1;
      rs_q    <= SeedFallback;
    end else begin
      rs_q <= rs_d;
      if (s1_fire) begin
        pos_q   <= (pos_d != PosSaturate) ? pos_d + 16'd1 : pos_d;
        len_q   <= len_d;
        ihb_q   <= ihb_d;
        proto_q <= proto_d;
        pend_q  <= pend_d;
        pass_q  <= pass_d || s1_eop_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_byte_q <= res_byte;
      out_last_q <= s1_eop_q;
      out_flip_q <= res_flips;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.out_last   = out_last_q;
  assign out_o.flip_count = out_flip_q;

  // flip count matches the bits that differ from the input byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> ($countones(out_byte_q ^ $past(s1_byte_q)) == 32'(out_flip_q)))
    else $error("flip count does not match changed bits");

  // zero threshold leaves the byte untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (thr_q == '0)) |=> (out_byte_q == $past(s1_byte_q)) && (out_flip_q == '0))
    else $error("byte changed with zero threshold");

  // generator holds when no bits are drawn and no seed is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(s1_fire && flip_en) && !seed_wr) |=> (rs_q == $past(rs_q)))
    else $error("generator advanced without drawing bits");

  // last byte of a packet returns to pass-through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_eop_q) |=> pass_q)
    else $error("pass-through not set after end of packet");

endmodule

`default_nettype wire
